// ===== src/bounded_deque_bag_core_defines.svh =====
// Assertion macros used by the deque datapath.
`ifndef BOUNDED_DEQUE_BAG_CORE_DEFINES_SVH
`define BOUNDED_DEQUE_BAG_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define BDB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define BDB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/bdb_pkg.sv =====
package bdb_pkg;

   // Request codes. Codes 6 and 7 do nothing.
   typedef enum logic [2:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_BACK  = 3'd1,
      REQ_POP_FRONT  = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_CONTAINS   = 3'd4,
      REQ_REMOVE     = 3'd5
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_code_type;

   // Which offset from the head the read port looks at.
   typedef enum logic [1:0] {
      OFF_IDX,
      OFF_IDX_NEXT,
      OFF_FRONT,
      OFF_BACK
   } rd_sel_type;

   typedef struct packed {
      logic       capture;
      logic       apply;
      logic       inc_idx;
      logic       set_found;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       shift_wr;
      logic       dec_count;
      logic       take_front;
      logic       take_back;
      logic       zero_ends;
      logic       load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic       count_zero;
      logic       match;
      logic       idx_last;
      logic       rsp_free;
   } dp_stat_type;

endpackage

// ===== src/bdb_ram.sv =====
module bdb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bdb_ctrl.sv =====
module bdb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output bdb_pkg::dp_cmd_type  cmd,
   input  bdb_pkg::dp_stat_type stat
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_RD_FRONT,
      ST_RD_BACK,
      ST_CAP_BACK,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      is_search;

   assign is_search = (stat.req_type == bdb_pkg::REQ_CONTAINS) ||
                      (stat.req_type == bdb_pkg::REQ_REMOVE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = bdb_pkg::OFF_IDX;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // No request is taken while reset is held.
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.apply = 1'b1;
            if (is_search && !stat.count_zero) begin
               state_in = ST_SRCH_RD;
            end else begin
               state_in = ST_RD_FRONT;
            end
         end
         ST_SRCH_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = bdb_pkg::OFF_IDX;
            state_in   = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            priority if (stat.match) begin
               cmd.set_found = 1'b1;
               state_in = (stat.req_type == bdb_pkg::REQ_REMOVE) ? ST_SHIFT_RD : ST_RD_FRONT;
            end else if (stat.idx_last) begin
               state_in = ST_RD_FRONT;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = ST_SRCH_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (stat.idx_last) begin
               cmd.dec_count = 1'b1;
               state_in      = ST_RD_FRONT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bdb_pkg::OFF_IDX_NEXT;
               state_in   = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            cmd.inc_idx  = 1'b1;
            state_in     = ST_SHIFT_RD;
         end
         ST_RD_FRONT: begin
            if (stat.count_zero) begin
               cmd.zero_ends = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bdb_pkg::OFF_FRONT;
               state_in   = ST_RD_BACK;
            end
         end
         ST_RD_BACK: begin
            cmd.take_front = 1'b1;
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = bdb_pkg::OFF_BACK;
            state_in       = ST_CAP_BACK;
         end
         ST_CAP_BACK: begin
            cmd.take_back = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/bdb_datapath.sv =====
`include "bounded_deque_bag_core_defines.svh"

module bdb_datapath #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bdb_pkg::dp_cmd_type  cmd,
   output bdb_pkg::dp_stat_type stat,
   input  logic [2:0]           req_type,
   input  logic signed [31:0]   req_item_value,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic signed [31:0]   rsp_front_value,
   output logic signed [31:0]   rsp_back_value,
   output logic [4:0]           rsp_item_count,
   output logic                 rsp_is_empty,
   output logic                 rsp_found,
   output logic [1:0]           rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [AW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic [2:0]             type_ff, type_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   found_ff, found_in;
   bdb_pkg::status_code_type status_ff, status_in;
   logic [VALUE_WIDTH-1:0] front_ff, front_in;
   logic [VALUE_WIDTH-1:0] back_ff, back_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_front_ff, rsp_front_in;
   logic [31:0]            rsp_back_ff, rsp_back_in;
   logic [4:0]             rsp_count_ff, rsp_count_in;
   logic                   rsp_empty_ff, rsp_empty_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;

   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [VALUE_WIDTH-1:0] mem_wdata;
   logic                   mem_re;
   logic [AW-1:0]          mem_raddr;
   logic [VALUE_WIDTH-1:0] mem_rdata;

   logic                   full;
   logic                   empty;
   logic [AW-1:0]          head_minus;
   logic [AW-1:0]          head_plus;
   logic [63:0]            value_wide;
   logic [63:0]            front_wide;
   logic [63:0]            back_wide;

   // Physical slot of a logical offset from the head; the sum stays below twice DEPTH.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [AW-1:0] offset);
      logic [AW:0] sum;
      sum = (AW+1)'(head) + (AW+1)'(offset);
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);
   assign head_minus = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign head_plus  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign value_wide = 64'($unsigned(req_item_value));
   assign front_wide = 64'(front_ff);
   assign back_wide  = 64'(back_ff);

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      type_in       = type_ff;
      value_in      = value_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      mem_we        = 1'b0;
      mem_waddr     = slot_of(head_ff, idx_ff);
      mem_wdata     = mem_rdata;

      if (cmd.capture) begin
         type_in   = req_type;
         value_in  = value_wide[VALUE_WIDTH-1:0];
         idx_in    = '0;
         found_in  = 1'b0;
         status_in = bdb_pkg::STATUS_OK;
      end

      if (cmd.apply) begin
         unique case (type_ff)
            bdb_pkg::REQ_PUSH_FRONT: begin
               if (full) begin
                  status_in = bdb_pkg::STATUS_FULL;
               end else begin
                  head_in   = head_minus;
                  mem_we    = 1'b1;
                  mem_waddr = head_minus;
                  mem_wdata = value_ff;
                  count_in  = count_ff + CW'(1);
               end
            end
            bdb_pkg::REQ_PUSH_BACK: begin
               if (full) begin
                  status_in = bdb_pkg::STATUS_FULL;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = slot_of(head_ff, AW'(count_ff));
                  mem_wdata = value_ff;
                  count_in  = count_ff + CW'(1);
               end
            end
            bdb_pkg::REQ_POP_FRONT: begin
               if (empty) begin
                  status_in = bdb_pkg::STATUS_EMPTY;
               end else begin
                  head_in  = head_plus;
                  count_in = count_ff - CW'(1);
               end
            end
            bdb_pkg::REQ_POP_BACK: begin
               if (empty) begin
                  status_in = bdb_pkg::STATUS_EMPTY;
               end else begin
                  count_in = count_ff - CW'(1);
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.inc_idx) begin
         idx_in = idx_ff + AW'(1);
      end
      if (cmd.set_found) begin
         found_in = 1'b1;
      end
      if (cmd.shift_wr) begin
         mem_we    = 1'b1;
         mem_waddr = slot_of(head_ff, idx_ff);
         mem_wdata = mem_rdata;
      end
      if (cmd.dec_count) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.take_front) begin
         front_in = mem_rdata;
      end
      if (cmd.take_back) begin
         back_in = mem_rdata;
      end
      if (cmd.zero_ends) begin
         front_in = '0;
         back_in  = '0;
      end
   end

   always_comb begin
      mem_re = cmd.rd_en;
      unique case (cmd.rd_sel)
         bdb_pkg::OFF_IDX:      mem_raddr = slot_of(head_ff, idx_ff);
         bdb_pkg::OFF_IDX_NEXT: mem_raddr = slot_of(head_ff, idx_ff + AW'(1));
         bdb_pkg::OFF_FRONT:    mem_raddr = head_ff;
         bdb_pkg::OFF_BACK:     mem_raddr = slot_of(head_ff, AW'(count_ff - CW'(1)));
         default:               mem_raddr = head_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_front_in  = front_wide[31:0];
         rsp_back_in   = back_wide[31:0];
         rsp_count_in  = 5'(count_ff);
         rsp_empty_in  = empty;
         rsp_found_in  = found_ff;
         rsp_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      type_ff       <= type_in;
      value_ff      <= value_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      front_ff      <= front_in;
      back_ff       <= back_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   bdb_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign stat.req_type   = type_ff;
   assign stat.count_zero = empty;
   assign stat.match      = (mem_rdata == value_ff);
   assign stat.idx_last   = ((CW+1)'(idx_ff) + (CW+1)'(1)) >= (CW+1)'(count_ff);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = signed'(rsp_front_ff);
   assign rsp_back_value  = signed'(rsp_back_ff);
   assign rsp_item_count  = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;

   `BDB_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "count above depth")
   `BDB_ASSERT_SAME(a_head_bound, clock, reset, 1'b1, (AW+1)'(head_ff) < (AW+1)'(DEPTH), "head out of range")
   `BDB_ASSERT_NEXT(a_full_push_holds, clock, reset, cmd.apply && full && ((type_ff == bdb_pkg::REQ_PUSH_FRONT) || (type_ff == bdb_pkg::REQ_PUSH_BACK)), (count_ff == $past(count_ff)) && (head_ff == $past(head_ff)), "rejected push changed the deque")
   `BDB_ASSERT_SAME(a_shift_in_range, clock, reset, cmd.shift_wr, ((CW+1)'(idx_ff) + (CW+1)'(1)) < (CW+1)'(count_ff), "compaction past the back")
   `BDB_ASSERT_SAME(a_load_when_free, clock, reset, cmd.load_rsp, !rsp_valid_ff || rsp_ready, "response overwritten before taken")

endmodule

// ===== src/bounded_deque_bag_core.sv =====
// Channel   Direction  Handshake            Payload
// request   in         req_valid/req_ready  req_type, req_item_value
// response  out        rsp_valid/rsp_ready  rsp_front_value, rsp_back_value, rsp_item_count,
//                                           rsp_is_empty, rsp_found, rsp_status
//
// One request at a time: it is applied, then front and back are read through the single store
// read port, and the response register is loaded and rsp_valid rises (the reads are skipped if the
// deque is left empty). Contains and remove compare stored elements from the front until a match
// or the back; remove then moves each later element one place toward the front.
// Reset is synchronous and active high; it empties the deque and holds req_ready low.
// A new request is taken while a response waits; the block stalls only when the next finished
// response finds the response register still occupied.
module bounded_deque_bag_core #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_type,
   input  logic signed [31:0] req_item_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_front_value,
   output logic signed [31:0] rsp_back_value,
   output logic [4:0]         rsp_item_count,
   output logic               rsp_is_empty,
   output logic               rsp_found,
   output logic [1:0]         rsp_status
);

   // The controller sequences each request; the datapath owns the store, the head and count
   // registers, and the response register.
   bdb_pkg::dp_cmd_type  cmd;
   bdb_pkg::dp_stat_type stat;

   bdb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Values are held as their low VALUE_WIDTH bits and shown zero-extended or truncated to
   // 32 bits. The count port shows the low five bits of the element count.
   bdb_datapath #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_type        (req_type),
      .req_item_value  (req_item_value),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_item_count  (rsp_item_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_found       (rsp_found),
      .rsp_status      (rsp_status)
   );

endmodule

// ===== tb/sv/bounded_deque_bag_core_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the bounded deque with value search.
//
// A mirror of the deque (circular store, head index and element count) is kept in a small
// class. Every request accepted by the block is applied to the mirror, which appends the
// response it expects to a queue. Every response taken from the block is compared field by
// field with the oldest entry in that queue.
//
// The stimulus starts with a short directed run over the empty-deque corner cases, the
// unused request codes and the value extremes. A long random run follows. It is organized
// in phases that lean toward filling, draining, balanced traffic or searching, so that the
// deque sweeps its whole range of occupancy, including full.
module bounded_deque_bag_core_test;

   localparam int DEPTH           = 16;
   localparam int RANDOM_REQUESTS = 1500;
   localparam int PHASE_LEN       = 60;
   // The limit has to cover the longest request (remove at full occupancy) and also the long
   // receiver hold-off below, so it is set well above both.
   localparam int IDLE_LIMIT      = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AT     = 400;
   localparam int TAIL_CYCLES     = 80;

   // Request codes 6 and 7 are not named in the package; the block treats them as no-ops.
   localparam logic [2:0] REQ_SPARE_6 = 3'd6;
   localparam logic [2:0] REQ_SPARE_7 = 3'd7;

   // Phases of the random run.
   localparam int MODE_FILL     = 0;
   localparam int MODE_DRAIN    = 1;
   localparam int MODE_BALANCED = 2;
   localparam int MODE_SEARCH   = 3;

   // One response of the block, as predicted or as observed.
   typedef struct packed {
      logic [31:0] front;
      logic [31:0] back;
      logic [4:0]  count;
      logic        empty;
      logic        found;
      logic [1:0]  status;
   } deque_snapshot_type;

   // Mirror of the deque. It applies each accepted request to its own copy of the state and
   // queues the response that request must produce.
   class deque_mirror;
      logic [31:0]        slots[DEPTH];
      logic [3:0]         head;
      logic [4:0]         count;
      deque_snapshot_type expected_snapshots[$];
      int                 mismatches;

      function new();
         head       = '0;
         count      = '0;
         mismatches = 0;
      endfunction

      function logic [3:0] slot_at(input int offset);
         logic [3:0] idx;
         idx = head + offset[3:0];
         return idx;
      endfunction

      // Offset of the first stored match seen from the front, or DEPTH when there is none.
      function int locate(input logic [31:0] value);
         for (int i = 0; i < count; i++) begin
            if (slots[slot_at(i)] == value) return i;
         end
         return DEPTH;
      endfunction

      function logic [31:0] pick_stored();
         return slots[slot_at($urandom_range(0, count - 1))];
      endfunction

      function int outstanding();
         return expected_snapshots.size();
      endfunction

      task report(input string what);
         $display("%0t mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      function void apply_request(input logic [2:0] code, input logic [31:0] value);
         deque_snapshot_type snap;
         int                 pos;
         snap        = '0;
         snap.status = bdb_pkg::STATUS_OK;
         case (code)
            bdb_pkg::REQ_PUSH_FRONT: begin
               if (count == DEPTH) begin
                  snap.status = bdb_pkg::STATUS_FULL;
               end else begin
                  head        = head - 4'd1;
                  slots[head] = value;
                  count++;
               end
            end
            bdb_pkg::REQ_PUSH_BACK: begin
               if (count == DEPTH) begin
                  snap.status = bdb_pkg::STATUS_FULL;
               end else begin
                  slots[slot_at(count)] = value;
                  count++;
               end
            end
            bdb_pkg::REQ_POP_FRONT: begin
               if (count == 0) begin
                  snap.status = bdb_pkg::STATUS_EMPTY;
               end else begin
                  head = head + 4'd1;
                  count--;
               end
            end
            bdb_pkg::REQ_POP_BACK: begin
               if (count == 0) snap.status = bdb_pkg::STATUS_EMPTY;
               else count--;
            end
            bdb_pkg::REQ_CONTAINS: begin
               snap.found = (locate(value) < DEPTH);
            end
            bdb_pkg::REQ_REMOVE: begin
               pos = locate(value);
               if (pos < DEPTH) begin
                  snap.found = 1'b1;
                  // Later elements slide one place toward the front to close the gap.
                  for (int i = pos; i + 1 < count; i++)
                     slots[slot_at(i)] = slots[slot_at(i + 1)];
                  count--;
               end
            end
            default: ;
         endcase
         if (count != 0) begin
            snap.front = slots[slot_at(0)];
            snap.back  = slots[slot_at(count - 1)];
         end
         snap.count = count;
         snap.empty = (count == 0);
         expected_snapshots.push_back(snap);
      endfunction

      task check_response(input deque_snapshot_type got);
         deque_snapshot_type want;
         if (expected_snapshots.size() == 0) begin
            report("response with no request outstanding");
         end else begin
            want = expected_snapshots.pop_front();
            if (got.front !== want.front)
               report($sformatf("front_value %h, expected %h", got.front, want.front));
            if (got.back !== want.back)
               report($sformatf("back_value %h, expected %h", got.back, want.back));
            if (got.count !== want.count)
               report($sformatf("item_count %0d, expected %0d", got.count, want.count));
            if (got.empty !== want.empty)
               report($sformatf("is_empty %b, expected %b", got.empty, want.empty));
            if (got.found !== want.found)
               report($sformatf("found %b, expected %b", got.found, want.found));
            if (got.status !== want.status)
               report($sformatf("status %0d, expected %0d", got.status, want.status));
         end
      endtask
   endclass

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   logic [2:0]         req_type       = bdb_pkg::REQ_PUSH_FRONT;
   logic signed [31:0] req_item_value = '0;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   logic signed [31:0] rsp_front_value;
   logic signed [31:0] rsp_back_value;
   logic [4:0]         rsp_item_count;
   logic               rsp_is_empty;
   logic               rsp_found;
   logic [1:0]         rsp_status;

   deque_mirror mirror = new();
   int          requests_sent  = 0;
   int          responses_seen = 0;
   int          idle_cycles    = 0;

   bounded_deque_bag_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_item_count  (rsp_item_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_found       (rsp_found),
      .rsp_status      (rsp_status)
   );

   always #10 clock = ~clock;

   // Offers one request and returns at the edge where it is accepted. Valid is lowered only
   // when a gap follows, so back-to-back requests keep it high without a glitch. Every 128
   // requests a stretch of 24 goes out with no gaps at all.
   task automatic send_request(input logic [2:0] code, input logic [31:0] value);
      int gap;
      gap = (requests_sent % 128 < 24) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= code;
      req_item_value <= value;
      do @(posedge clock); while (!req_ready);
      mirror.apply_request(code, value);
      requests_sent++;
   endtask

   // Values lean toward the extremes and a handful of small numbers, so that duplicates are
   // common and searches hit often; the rest are full-width random.
   function automatic logic [31:0] draw_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3, 4, 5: return $urandom_range(0, 7);
         default: return $urandom();
      endcase
   endfunction

   // Response side. It stalls at random, runs stall-free for 20 of every 100 responses, and
   // once holds off for a long stretch while the sender keeps offering requests, so that the
   // response register fills and the block has to stop taking requests.
   initial begin
      int                 stall;
      deque_snapshot_type got;
      @(negedge reset);
      forever begin
         if (responses_seen == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
         else if (responses_seen % 100 < 20) stall = 0;
         else stall = $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.front  = rsp_front_value;
         got.back   = rsp_back_value;
         got.count  = rsp_item_count;
         got.empty  = rsp_is_empty;
         got.found  = rsp_found;
         got.status = rsp_status;
         mirror.check_response(got);
         responses_seen++;
      end
   end

   // Watchdog: any accepted request or response clears the count of quiet cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      int          mode;
      int          push_pct;
      int          pop_pct;
      int          roll;
      logic [2:0]  code;
      logic [31:0] value;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Everything on an empty deque must leave it empty and flag pops.
      send_request(bdb_pkg::REQ_POP_FRONT, 32'h1234_5678);
      send_request(bdb_pkg::REQ_POP_BACK, 32'hFFFF_FFFF);
      send_request(bdb_pkg::REQ_CONTAINS, 32'h0000_0000);
      send_request(bdb_pkg::REQ_REMOVE, 32'h0000_0000);
      send_request(REQ_SPARE_6, 32'h5555_5555);
      send_request(REQ_SPARE_7, 32'hAAAA_AAAA);
      // Extremes at both ends, giving front to back: -1, min, max, 0.
      send_request(bdb_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
      send_request(bdb_pkg::REQ_PUSH_BACK, 32'h7FFF_FFFF);
      send_request(bdb_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF);
      send_request(bdb_pkg::REQ_PUSH_BACK, 32'h0000_0000);
      send_request(REQ_SPARE_7, 32'h0000_0001);
      send_request(bdb_pkg::REQ_CONTAINS, 32'h7FFF_FFFF);
      send_request(bdb_pkg::REQ_CONTAINS, 32'h0000_0005);
      // A removal from the middle must keep the order of the rest.
      send_request(bdb_pkg::REQ_REMOVE, 32'h8000_0000);
      send_request(bdb_pkg::REQ_REMOVE, 32'h0000_007B);
      send_request(bdb_pkg::REQ_PUSH_BACK, 32'hFFFF_FFFF);
      // With a duplicate present, only the first match from the front goes.
      send_request(bdb_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
      send_request(bdb_pkg::REQ_REMOVE, 32'h0000_0000);
      send_request(bdb_pkg::REQ_POP_FRONT, 32'h0000_0000);
      send_request(bdb_pkg::REQ_POP_BACK, 32'h0000_0000);
      send_request(bdb_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
      send_request(bdb_pkg::REQ_POP_BACK, 32'h0000_0000);

      // Random part, in phases that push the occupancy around the whole range.
      mode = MODE_BALANCED;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % PHASE_LEN == 0) mode = $urandom_range(MODE_FILL, MODE_SEARCH);
         case (mode)
            MODE_FILL:  begin push_pct = 80; pop_pct = 8;  end
            MODE_DRAIN: begin push_pct = 12; pop_pct = 70; end
            MODE_SEARCH: begin push_pct = 25; pop_pct = 15; end
            default:    begin push_pct = 40; pop_pct = 35; end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < push_pct)
            code = $urandom_range(0, 1) ? bdb_pkg::REQ_PUSH_BACK : bdb_pkg::REQ_PUSH_FRONT;
         else if (roll < push_pct + pop_pct)
            code = $urandom_range(0, 1) ? bdb_pkg::REQ_POP_BACK : bdb_pkg::REQ_POP_FRONT;
         else if (roll >= 97)
            code = $urandom_range(0, 1) ? REQ_SPARE_7 : REQ_SPARE_6;
         else
            code = $urandom_range(0, 1) ? bdb_pkg::REQ_REMOVE : bdb_pkg::REQ_CONTAINS;
         // Most searches look for a value that is actually stored.
         if ((code == bdb_pkg::REQ_CONTAINS || code == bdb_pkg::REQ_REMOVE) &&
             mirror.count != 0 && $urandom_range(0, 9) < 6)
            value = mirror.pick_stored();
         else
            value = draw_value();
         send_request(code, value);
      end
      req_valid <= 1'b0;

      // Drain the outstanding responses, then give the block time to show any stray ones.
      while (mirror.outstanding() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mirror.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
